// File: design/lla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types and codes for the cellular automaton step core.
// ----------------------------------------------------------------------------
package lla_pkg;
    localparam int ActW = 3;
    localparam int RowW = 6;
    localparam int ColW = 7;
    localparam int MaskW = 9;

    localparam logic [ActW-1:0] ACT_WRITE  = 3'd0;
    localparam logic [ActW-1:0] ACT_TOGGLE = 3'd1;
    localparam logic [ActW-1:0] ACT_READ   = 3'd2;
    localparam logic [ActW-1:0] ACT_STEP   = 3'd3;
    localparam logic [ActW-1:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] CFG_BIRTH    = 2'd0;
    localparam logic [1:0] CFG_SURVIVAL = 2'd1;
    localparam logic [1:0] CFG_HEX      = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic cell_rd;     // issue read of addressed cell
        logic cell_wr;     // write addressed cell
        logic toggle;      // write data is inverse of read data
        logic clr_start;   // reset sweep counters
        logic clr_wr;      // clear-sweep write
        logic gen_start;   // reset generation counters
        logic gen_run;     // advance generation pipeline one cell
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;  // clear sweep at last address
        logic gen_done;    // final cell of generation written
    } t_sts;
endpackage

// File: design/lla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_ram
// Generic single-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module lla_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/lla_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_datapath
// Grid memory, clear sweep and generation sweep with a 3x3 window.
// Generation: old grid read from bank A in raster order; new cells go to bank
// B; bank roles swap at the end (cur select bit). Two line-buffer shift
// registers hold the rows above, three window shift registers form the 3x3
// neighborhood together with the column arriving this cycle.
// ----------------------------------------------------------------------------
module lla_datapath #(
    parameter int ROWS = 60,
    parameter int COLS = 80
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lla_pkg::t_cmd                   i_cmd,
    output lla_pkg::t_sts                   o_sts,
    input  logic [lla_pkg::RowW-1:0]        i_row,
    input  logic [lla_pkg::ColW-1:0]        i_col,
    input  logic                            i_wval,
    input  logic [lla_pkg::MaskW-1:0]       i_birth,
    input  logic [lla_pkg::MaskW-1:0]       i_surv,
    input  logic                            i_hex,
    output logic                            o_rdata
);
    localparam int Depth = ROWS * COLS;
    localparam int AW = $clog2(Depth);
    localparam int RW = $clog2(ROWS + 2);
    localparam int CW = $clog2(COLS + 2);

    // bank select: which of the two grids is current
    logic r_cur;
    logic [AW-1:0] addr_cell;
    assign addr_cell = AW'(i_row) * AW'(COLS) + AW'(i_col);

    // addressed cell and write value, held from acceptance
    logic [AW-1:0] r_caddr;
    logic r_wval;

    // read-scan position (reads run one row + one col ahead of output)
    logic [RW-1:0] r_rr, n_rr;
    logic [CW-1:0] r_rc, n_rc;
    logic [AW-1:0] r_ra, n_ra;
    // position of the bit arriving from the RAM
    logic [RW-1:0] r_or;
    logic [CW-1:0] r_oc;
    logic [AW-1:0] r_oa;
    logic [AW-1:0] r_sw;            // clear sweep address
    logic r_vld;                    // read issued last cycle (generation)
    logic r_rin;                    // last read position inside grid

    // one padded row per line buffer; tail holds the same column one row up
    logic [COLS:0] r_lb1, r_lb0;
    logic [1:0] r_wt, r_wm, r_wb;   // two previous window columns, [0] newer

    logic [AW-1:0] rd_addr [2];
    logic [AW-1:0] wr_addr [2];
    logic we [2], wd [2], rd [2];

    genvar g;
    generate
        for (g = 0; g < 2; g++) begin : g_bank
            lla_ram #(.WIDTH(1), .DEPTH(Depth)) u_ram (
                .i_clk  (i_clk),
                .i_we   (we[g]),
                .i_waddr(wr_addr[g]),
                .i_wdata(wd[g]),
                .i_raddr(rd_addr[g]),
                .o_rdata(rd[g])
            );
        end
    endgenerate

    logic old_bit, new_bit, cur_rd;
    logic top_now, mid_now;
    logic [2:0] win_t, win_m, win_b;
    logic in_gen_w;
    logic [3:0] cnt;
    logic ctr;
    logic [lla_pkg::MaskW-1:0] rule;

    assign cur_rd = r_cur ? rd[1] : rd[0];
    assign o_rdata = cur_rd;
    assign old_bit = r_rin & cur_rd;
    assign top_now = r_lb1[COLS];
    assign mid_now = r_lb0[COLS];

    // window center is (r_or-1, r_oc-1); column [0] is the one arriving now
    always_comb begin
        win_t = {r_wt, top_now};
        win_m = {r_wm, mid_now};
        win_b = {r_wb, old_bit};
        ctr = win_m[1];
        cnt = 4'(win_t[1]) + 4'(win_b[1]) + 4'(win_m[2]) + 4'(win_m[0])
            + 4'(win_t[2]) + 4'(win_b[0]);
        if (!i_hex) begin
            cnt = cnt + 4'(win_b[2]) + 4'(win_t[0]);
        end
        rule = ctr ? i_surv : i_birth;
        new_bit = rule[cnt];
        in_gen_w = (r_or >= RW'(1)) && (r_oc >= CW'(1));
    end

    // raster over (ROWS+1) x (COLS+1) read positions; output lags 1 row, 1 col
    always_comb begin
        n_rr = r_rr;
        n_rc = r_rc;
        n_ra = r_ra;
        if (i_cmd.gen_start) begin
            n_rr = '0;
            n_rc = '0;
            n_ra = '0;
        end else if (i_cmd.gen_run) begin
            if (r_rc == CW'(COLS)) begin
                n_rc = '0;
                n_rr = r_rr + RW'(1);
            end else begin
                n_rc = r_rc + CW'(1);
            end
            if ((r_rr < RW'(ROWS)) && (r_rc < CW'(COLS))) begin
                n_ra = r_ra + AW'(1);
            end
        end
    end

    logic gen_wr;
    assign gen_wr = i_cmd.gen_run && r_vld && in_gen_w;

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            rd_addr[b] = i_cmd.gen_run ? r_ra : addr_cell;
            wr_addr[b] = r_caddr;
            wd[b]      = 1'b0;
            we[b]      = 1'b0;
        end
        if (i_cmd.clr_wr) begin
            wr_addr[r_cur] = r_sw;
            we[r_cur] = 1'b1;
        end else if (i_cmd.cell_wr) begin
            wd[r_cur] = i_cmd.toggle ? ~cur_rd : r_wval;
            we[r_cur] = 1'b1;
        end else if (gen_wr) begin
            wr_addr[~r_cur] = r_oa;
            wd[~r_cur] = new_bit;
            we[~r_cur] = 1'b1;
        end
    end

    logic rd_in;
    assign rd_in = (r_rr < RW'(ROWS)) && (r_rc < CW'(COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 1'b0;
            r_vld <= 1'b0;
            r_sw <= '0;
        end else begin
            r_vld <= i_cmd.gen_run;
            if (o_sts.gen_done) begin
                r_cur <= ~r_cur;
            end
            if (i_cmd.clr_start) begin
                r_sw <= '0;
            end else if (i_cmd.clr_wr) begin
                r_sw <= r_sw + AW'(1);
            end
        end
        r_rr <= n_rr;
        r_rc <= n_rc;
        r_ra <= n_ra;
        if (i_cmd.cell_rd) begin
            r_caddr <= addr_cell;
            r_wval <= i_wval;
        end
        if (i_cmd.gen_run) begin
            r_rin <= rd_in;
        end
        if (i_cmd.gen_start) begin
            r_oa <= '0;
            r_or <= '0;
            r_oc <= '0;
            r_wt <= '0;
            r_wm <= '0;
            r_wb <= '0;
            r_lb1 <= '0;
            r_lb0 <= '0;
        end else if (i_cmd.gen_run && r_vld) begin
            // consume the bit read last cycle, padding column included
            r_lb0 <= {r_lb0[COLS-1:0], old_bit};
            r_lb1 <= {r_lb1[COLS-1:0], mid_now};
            if (r_oc == CW'(COLS)) begin
                r_oc <= '0;
                r_or <= r_or + RW'(1);
                r_wt <= '0;
                r_wm <= '0;
                r_wb <= '0;
            end else begin
                r_oc <= r_oc + CW'(1);
                r_wt <= {r_wt[0], top_now};
                r_wm <= {r_wm[0], mid_now};
                r_wb <= {r_wb[0], old_bit};
            end
            if (gen_wr) begin
                r_oa <= r_oa + AW'(1);
            end
        end
    end

    assign o_sts.sweep_last = (r_sw == AW'(Depth - 1));
    assign o_sts.gen_done = gen_wr && (r_oa == AW'(Depth - 1));
endmodule

// File: design/lla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_ctrl
// Controller: input handshake, command sequencing, output register.
// ----------------------------------------------------------------------------
module lla_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [lla_pkg::ActW-1:0] i_action,
    input  logic                     i_inside,
    input  logic                     i_cell_value,
    output lla_pkg::t_cmd            o_cmd,
    input  lla_pkg::t_sts            i_sts,
    input  logic                     i_rdata,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_cell_state
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CLR  = 3'd2;
    localparam logic [2:0] ST_GEN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_INIT = 3'd5;

    logic [2:0] r_st, n_st;
    logic [lla_pkg::ActW-1:0] r_act;
    logic r_val, r_ovld, r_ostate;
    logic fire, done_now, res_bit;

    assign o_ready = (r_st == ST_IDLE) && (!r_ovld || i_ready);
    assign fire = i_valid && o_ready;

    always_comb begin
        o_cmd = '0;
        n_st = r_st;
        done_now = 1'b0;
        res_bit = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (fire) begin
                    if (i_action == lla_pkg::ACT_STEP) begin
                        o_cmd.gen_start = 1'b1;
                        n_st = ST_GEN;
                    end else if (i_action == lla_pkg::ACT_CLEAR) begin
                        o_cmd.clr_start = 1'b1;
                        n_st = ST_CLR;
                    end else if (i_inside && (i_action == lla_pkg::ACT_WRITE
                            || i_action == lla_pkg::ACT_TOGGLE
                            || i_action == lla_pkg::ACT_READ)) begin
                        o_cmd.cell_rd = 1'b1;
                        n_st = ST_RD;
                    end else begin
                        n_st = ST_DONE;
                    end
                end
            end
            ST_RD: begin
                // read data valid; apply write or toggle, or pass it on for a read
                done_now = 1'b1;
                priority if (r_act == lla_pkg::ACT_WRITE) begin
                    o_cmd.cell_wr = 1'b1;
                    res_bit = r_val;
                end else if (r_act == lla_pkg::ACT_TOGGLE) begin
                    o_cmd.cell_wr = 1'b1;
                    o_cmd.toggle = 1'b1;
                    res_bit = ~i_rdata;
                end else begin
                    res_bit = i_rdata;
                end
                n_st = ST_IDLE;
            end
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    done_now = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            ST_INIT: begin
                // grid clear after reset, no result
                o_cmd.clr_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_st = ST_IDLE;
                end
            end
            ST_GEN: begin
                o_cmd.gen_run = 1'b1;
                if (i_sts.gen_done) begin
                    done_now = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            ST_DONE: begin
                done_now = 1'b1;
                n_st = ST_IDLE;
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_INIT;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (done_now) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
        if (fire) begin
            r_act <= i_action;
            r_val <= i_cell_value;
        end
        if (done_now) begin
            r_ostate <= res_bit;
        end
    end

    assign o_valid = r_ovld;
    assign o_cell_state = r_ostate;
endmodule

// File: design/life_like_automaton_step_core.sv
`timescale 1ns / 1ps
// Sequencing: write/toggle/read pass through ST_RD, bad-address and unused actions
// through ST_DONE, each then into the result register; clear sweeps every address; step
// is a raster sweep with one zero-padding row and column, one RAM read per cycle.
// Flow: one transaction at a time; the next is accepted once idle with the result
// register free or being read out.
// Reset: sync active low; masks B3/S23, square mode, then a clear of the whole grid.
// ----------------------------------------------------------------------------
// life_like_automaton_step_core
// Life-like automaton with B/S rule masks over a ROWS x COLS grid.
// ----------------------------------------------------------------------------
module life_like_automaton_step_core #(
    parameter int ROWS = 60,
    parameter int COLS = 80
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lla_pkg::ActW-1:0]    i_action,
    input  logic [lla_pkg::RowW-1:0]    i_row,
    input  logic [lla_pkg::ColW-1:0]    i_col,
    input  logic                        i_cell_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_cell_state,
    output logic                        o_done_res,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [lla_pkg::MaskW-1:0]   i_cfg_data
);
    logic [lla_pkg::MaskW-1:0] r_birth, r_surv;
    logic r_hex;
    lla_pkg::t_cmd cmd;
    lla_pkg::t_sts sts;
    logic rdata, addr_ok;

    assign addr_ok = (32'(i_row) < ROWS) && (32'(i_col) < COLS);
    assign o_done_res = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth <= lla_pkg::MaskW'(8);
            r_surv <= lla_pkg::MaskW'(12);
            r_hex <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lla_pkg::CFG_BIRTH:    r_birth <= i_cfg_data;
                lla_pkg::CFG_SURVIVAL: r_surv <= i_cfg_data;
                lla_pkg::CFG_HEX:      r_hex <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lla_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_action(i_action),
        .i_inside(addr_ok), .i_cell_value(i_cell_value),
        .o_cmd(cmd), .i_sts(sts), .i_rdata(rdata),
        .o_valid(o_valid), .i_ready(i_ready), .o_cell_state(o_cell_state)
    );

    lla_datapath #(.ROWS(ROWS), .COLS(COLS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_row(i_row), .i_col(i_col), .i_wval(i_cell_value),
        .i_birth(r_birth), .i_surv(r_surv), .i_hex(r_hex), .o_rdata(rdata)
    );
endmodule

// File: design/lla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_checker
// Port-level checks for the automaton core.
// ----------------------------------------------------------------------------
module lla_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_cell_state,
    input logic o_done_res
);
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_done_res) else $error("done flag low");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cell_state))
        else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("accepted twice");
endmodule

bind life_like_automaton_step_core lla_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_cell_state(o_cell_state),
    .o_done_res(o_done_res)
);
